@@ rtl/dtbs_pkg.sv @@
package dtbs_pkg;

   // field widths
   localparam int unsigned LEN_W  = 17;
   localparam int unsigned TAG_W  = 16;
   localparam int unsigned TIME_W = 48;
   localparam int unsigned RATE_W = 32;
   localparam int unsigned CNT_OUT_W = 7;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 32;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // register reset values
   localparam logic [31:0] BURST_RST  = 32'd80000;
   localparam logic [31:0] MRATE_RST  = 32'd65536;
   localparam logic [16:0] MTU_RST    = 17'd12000;
   localparam logic [31:0] PRATE_RST  = 32'd655360;
   localparam logic [6:0]  QLIM_RST   = 7'd64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BURST = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MRATE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MTU   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRATE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_QLIM  = 3'd4;

   // commands
   localparam logic [1:0] CMD_ARRIVAL = 2'd0;
   localparam logic [1:0] CMD_REQUEST = 2'd1;
   localparam logic [1:0] CMD_TICK    = 2'd2;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [TAG_W-1:0] tag;
   } fifo_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOAD,
      ST_MUL,
      ST_MEAN,
      ST_PEAK,
      ST_TEST,
      ST_DIVM_GO,
      ST_DIVM_WAIT,
      ST_DIVP_GO,
      ST_DIVP_WAIT,
      ST_SCHED,
      ST_DONE
   } state_type;

endpackage

@@ rtl/dtbs_fifo.sv @@
module dtbs_fifo #(
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned ADDR_W = 6
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  dtbs_pkg::fifo_entry_type wr_data,
   input  logic [ADDR_W-1:0]       rd_addr,
   output dtbs_pkg::fifo_entry_type rd_data
);

   dtbs_pkg::fifo_entry_type mem [DEPTH];
   dtbs_pkg::fifo_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/dtbs_div.sv @@
module dtbs_div #(
   parameter int unsigned NUM_W = 34,
   parameter int unsigned DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   // one restoring step: shift in the next numerator bit
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      fits  = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
            rem_ff  <= '0;
            quo_ff  <= numer;
            den_ff  <= denom;
         end else if (busy_ff) begin
            rem_ff <= fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

@@ rtl/dual_token_bucket_shaper.sv @@
// when a resume is scheduled, its two divisions run serially on one shared divider;
// while a result stalls, the next result waits in the done state
// throughput: one transaction at a time; the next is accepted in the cycle after the
// result register loads
// reset: synchronous, active high; registers and buckets return to defaults, queue storage is not cleared
module dual_token_bucket_shaper #(
   parameter int unsigned QUEUE_DEPTH    = 64,
   parameter int unsigned RATE_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [47:0] req_now_ticks,
   input  logic [16:0] req_pkt_length,
   input  logic [15:0] req_pkt_tag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_released,
   output logic [15:0] rsp_released_tag,
   output logic [16:0] rsp_released_length,
   output logic        rsp_dropped,
   output logic        rsp_shaped,
   output logic [6:0]  rsp_queue_count,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SHL_W = 17 + RATE_FRAC_BITS;
   localparam int unsigned NUM_W = (SHL_W > 32 ? SHL_W : 32) + 1;
   localparam logic [80:0] HALF  = (81'd1 << RATE_FRAC_BITS) >> 1;

   dtbs_pkg::state_type state_ff, state_in;

   // configuration
   logic [31:0] burst_ff, mrate_ff, prate_ff;
   logic [16:0] mtu_ff;
   logic [6:0]  qlim_ff;

   // shaper state
   logic [31:0]      mean_tok_ff;
   logic [16:0]      peak_tok_ff;
   logic [47:0]      last_ff, resume_at_ff;
   logic             resume_ff;
   logic [15:0]      pend_ff;
   logic [PTR_W-1:0] head_ff, tail_ff;
   logic [CNT_W-1:0] held_ff;

   // current transaction
   logic [1:0]  cmd_ff;
   logic [47:0] now_ff, elapsed_ff;
   logic [16:0] len_ff;
   logic [15:0] tag_ff;
   logic        arrival_ff;
   logic [1:0]  mul_sel_ff;
   logic [63:0] plo_m_ff, plo_p_ff;
   logic [47:0] phi_m_ff, phi_p_ff, dm_ff, dp_ff;
   logic        res_rel_ff, res_drop_ff, res_shaped_ff;

   // output register
   logic        rsp_valid_ff, rsp_rel_ff, rsp_drop_ff, rsp_shaped_ff;
   logic [15:0] rsp_tag_ff;
   logic [16:0] rsp_len_ff;
   logic [6:0]  rsp_cnt_ff;

   logic                     push, pop, q_full, tick_fire, serve, serve_idle, arr_test;
   logic                     conform, out_free, div_start, div_done;
   logic [31:0]              held_ext;
   logic [63:0]              prod;
   logic [16:0]              def_m, def_p, def_sel;
   logic [31:0]              rate_sel;
   logic [NUM_W-1:0]         div_numer, div_quot;
   logic [47:0]              wait_ticks, d_max;
   logic [48:0]              resume_sum;
   dtbs_pkg::fifo_entry_type fifo_wdata, fifo_rdata;

   // refill one bucket by round(rate * elapsed), clipped to its cap
   function automatic logic [31:0] refill(input logic [31:0] tok, input logic [63:0] plo,
                                          input logic [47:0] phi, input logic [31:0] cap);
      logic [80:0] full;
      logic [80:0] shifted;
      logic [63:0] inc;
      logic [32:0] t;
      logic [31:0] r;
      full    = {1'b0, phi, 32'b0} + {17'b0, plo} + HALF;
      shifted = full >> RATE_FRAC_BITS;
      inc     = shifted[63:0];
      t       = {1'b0, tok} + {1'b0, inc[31:0]};
      if (full[80:64] != 17'd0) begin
         r = cap;
      end else if (inc >= {32'b0, cap}) begin
         r = cap;
      end else if (t > {1'b0, cap}) begin
         r = cap;
      end else begin
         r = t[31:0];
      end
      return r;
   endfunction

   // decode conditions
   always_comb begin
      held_ext   = 32'(held_ff);
      q_full     = (held_ext >= 32'(qlim_ff)) || (held_ext >= 32'(QUEUE_DEPTH));
      tick_fire  = (cmd_ff == dtbs_pkg::CMD_TICK) && resume_ff && (now_ff >= resume_at_ff);
      serve      = (cmd_ff == dtbs_pkg::CMD_REQUEST) || tick_fire;
      serve_idle = (held_ff == '0) || ((cmd_ff == dtbs_pkg::CMD_REQUEST) && resume_ff);
      arr_test   = (pend_ff != 16'd0) && !resume_ff;
      conform    = ({15'b0, len_ff} <= mean_tok_ff) && (len_ff <= peak_tok_ff);
      out_free   = !rsp_valid_ff || !rsp_stall;
      push = ((state_ff == dtbs_pkg::ST_DECODE) && (cmd_ff == dtbs_pkg::CMD_ARRIVAL)
              && !arr_test && !q_full)
          || ((state_ff == dtbs_pkg::ST_TEST) && !conform && arrival_ff && !q_full);
      pop  = (state_ff == dtbs_pkg::ST_TEST) && conform && !arrival_ff;
   end

   // shared multiplier: mean lo, mean hi, peak lo, peak hi
   always_comb begin
      logic [31:0] mul_a, mul_b;
      mul_a = mul_sel_ff[1] ? prate_ff : mrate_ff;
      mul_b = mul_sel_ff[0] ? {16'b0, elapsed_ff[47:32]} : elapsed_ff[31:0];
      prod  = mul_a * mul_b;
   end

   // deficits and divider operands
   always_comb begin
      def_m = ({15'b0, len_ff} > mean_tok_ff) ? (len_ff - mean_tok_ff[16:0]) : 17'd0;
      def_p = (len_ff > peak_tok_ff) ? (len_ff - peak_tok_ff) : 17'd0;
      if (state_ff == dtbs_pkg::ST_DIVP_GO || state_ff == dtbs_pkg::ST_DIVP_WAIT) begin
         def_sel  = def_p;
         rate_sel = prate_ff;
      end else begin
         def_sel  = def_m;
         rate_sel = mrate_ff;
      end
      div_numer = (NUM_W'(def_sel) << RATE_FRAC_BITS) + NUM_W'(rate_sel) - NUM_W'(1);
      if (def_sel == 17'd0) begin
         wait_ticks = '0;
      end else if (rate_sel == 32'd0) begin
         wait_ticks = dtbs_pkg::TIME_MAX;
      end else begin
         wait_ticks = 48'(div_quot);
      end
      d_max      = (dm_ff > dp_ff) ? dm_ff : dp_ff;
      resume_sum = {1'b0, now_ff} + {1'b0, d_max};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtbs_pkg::ST_IDLE:
            if (req_valid) state_in = dtbs_pkg::ST_DECODE;
         dtbs_pkg::ST_DECODE: begin
            if (cmd_ff == dtbs_pkg::CMD_ARRIVAL) begin
               state_in = arr_test ? dtbs_pkg::ST_MUL : dtbs_pkg::ST_DONE;
            end else if (serve) begin
               state_in = serve_idle ? dtbs_pkg::ST_DONE : dtbs_pkg::ST_LOAD;
            end else begin
               state_in = dtbs_pkg::ST_DONE;
            end
         end
         dtbs_pkg::ST_LOAD:
            state_in = dtbs_pkg::ST_MUL;
         dtbs_pkg::ST_MUL:
            if (mul_sel_ff == 2'd3) state_in = dtbs_pkg::ST_MEAN;
         dtbs_pkg::ST_MEAN:
            state_in = dtbs_pkg::ST_PEAK;
         dtbs_pkg::ST_PEAK:
            state_in = dtbs_pkg::ST_TEST;
         dtbs_pkg::ST_TEST: begin
            if (conform || (arrival_ff && q_full)) state_in = dtbs_pkg::ST_DONE;
            else state_in = dtbs_pkg::ST_DIVM_GO;
         end
         dtbs_pkg::ST_DIVM_GO:
            state_in = dtbs_pkg::ST_DIVM_WAIT;
         dtbs_pkg::ST_DIVM_WAIT:
            if (div_done) state_in = dtbs_pkg::ST_DIVP_GO;
         dtbs_pkg::ST_DIVP_GO:
            state_in = dtbs_pkg::ST_DIVP_WAIT;
         dtbs_pkg::ST_DIVP_WAIT:
            if (div_done) state_in = dtbs_pkg::ST_SCHED;
         dtbs_pkg::ST_SCHED:
            state_in = dtbs_pkg::ST_DONE;
         dtbs_pkg::ST_DONE:
            if (out_free) state_in = dtbs_pkg::ST_IDLE;
         default:
            state_in = dtbs_pkg::ST_IDLE;
      endcase
   end

   // state-driven outputs
   always_comb begin
      req_stall = (state_ff != dtbs_pkg::ST_IDLE);
      div_start = (state_ff == dtbs_pkg::ST_DIVM_GO) || (state_ff == dtbs_pkg::ST_DIVP_GO);
   end

   always_ff @(posedge clock) begin
      state_ff <= reset ? dtbs_pkg::ST_IDLE : state_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff <= dtbs_pkg::BURST_RST;
         mrate_ff <= dtbs_pkg::MRATE_RST;
         mtu_ff   <= dtbs_pkg::MTU_RST;
         prate_ff <= dtbs_pkg::PRATE_RST;
         qlim_ff  <= dtbs_pkg::QLIM_RST;
      end else if (csr_we) begin
         case (csr_index)
            dtbs_pkg::CSR_BURST: burst_ff <= csr_wdata;
            dtbs_pkg::CSR_MRATE: mrate_ff <= csr_wdata;
            dtbs_pkg::CSR_MTU:   mtu_ff   <= csr_wdata[16:0];
            dtbs_pkg::CSR_PRATE: prate_ff <= csr_wdata;
            dtbs_pkg::CSR_QLIM:  qlim_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // queue pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         held_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
            held_ff <= held_ff + 1'b1;
         end
         if (pop) begin
            head_ff <= (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            held_ff <= held_ff - 1'b1;
         end
      end
   end

   // bucket and request state
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_tok_ff  <= dtbs_pkg::BURST_RST;
         peak_tok_ff  <= dtbs_pkg::MTU_RST;
         last_ff      <= '0;
         resume_ff    <= 1'b0;
         resume_at_ff <= '0;
         pend_ff      <= '0;
      end else begin
         case (state_ff)
            dtbs_pkg::ST_DECODE: begin
               if (serve) begin
                  if (tick_fire) resume_ff <= 1'b0;
                  if (serve_idle && pend_ff != 16'hFFFF) pend_ff <= pend_ff + 1'b1;
               end
            end
            dtbs_pkg::ST_MEAN:
               mean_tok_ff <= refill(mean_tok_ff, plo_m_ff, phi_m_ff, burst_ff);
            dtbs_pkg::ST_PEAK: begin
               peak_tok_ff <= 17'(refill({15'b0, peak_tok_ff}, plo_p_ff, phi_p_ff,
                                         {15'b0, mtu_ff}));
               last_ff     <= now_ff;
            end
            dtbs_pkg::ST_TEST: begin
               if (conform) begin
                  mean_tok_ff <= mean_tok_ff - {15'b0, len_ff};
                  peak_tok_ff <= peak_tok_ff - len_ff;
                  if (arrival_ff) pend_ff <= pend_ff - 1'b1;
               end else if (arrival_ff && !q_full) begin
                  pend_ff <= pend_ff - 1'b1;
               end
            end
            dtbs_pkg::ST_SCHED: begin
               resume_ff    <= 1'b1;
               resume_at_ff <= resume_sum[48] ? dtbs_pkg::TIME_MAX : resume_sum[47:0];
            end
            default: ;
         endcase
      end
   end

   // transaction datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         dtbs_pkg::ST_IDLE: begin
            cmd_ff        <= req_command;
            now_ff        <= req_now_ticks;
            len_ff        <= req_pkt_length;
            tag_ff        <= req_pkt_tag;
            res_rel_ff    <= 1'b0;
            res_drop_ff   <= 1'b0;
            res_shaped_ff <= 1'b0;
         end
         dtbs_pkg::ST_DECODE: begin
            elapsed_ff <= (now_ff >= last_ff) ? now_ff - last_ff : '0;
            mul_sel_ff <= '0;
            arrival_ff <= (cmd_ff == dtbs_pkg::CMD_ARRIVAL);
            if (cmd_ff == dtbs_pkg::CMD_ARRIVAL && !arr_test && q_full) res_drop_ff <= 1'b1;
         end
         dtbs_pkg::ST_LOAD: begin
            len_ff <= fifo_rdata.len;
            tag_ff <= fifo_rdata.tag;
         end
         dtbs_pkg::ST_MUL: begin
            case (mul_sel_ff)
               2'd0: plo_m_ff <= prod;
               2'd1: phi_m_ff <= prod[47:0];
               2'd2: plo_p_ff <= prod;
               default: phi_p_ff <= prod[47:0];
            endcase
            mul_sel_ff <= mul_sel_ff + 1'b1;
         end
         dtbs_pkg::ST_TEST: begin
            if (conform) res_rel_ff <= 1'b1;
            else if (arrival_ff && q_full) res_drop_ff <= 1'b1;
            else res_shaped_ff <= 1'b1;
         end
         dtbs_pkg::ST_DIVM_WAIT:
            if (div_done) dm_ff <= wait_ticks;
         dtbs_pkg::ST_DIVP_WAIT:
            if (div_done) dp_ff <= wait_ticks;
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == dtbs_pkg::ST_DONE && out_free) begin
         rsp_valid_ff  <= 1'b1;
         rsp_rel_ff    <= res_rel_ff;
         rsp_tag_ff    <= res_rel_ff ? tag_ff : 16'd0;
         rsp_len_ff    <= res_rel_ff ? len_ff : 17'd0;
         rsp_drop_ff   <= res_drop_ff;
         rsp_shaped_ff <= res_shaped_ff;
         rsp_cnt_ff    <= held_ext[6:0];
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign fifo_wdata = '{len: len_ff, tag: tag_ff};

   dtbs_fifo #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (PTR_W)
   ) u_fifo (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (fifo_wdata),
      .rd_addr (head_ff),
      .rd_data (fifo_rdata)
   );

   dtbs_div #(
      .NUM_W (NUM_W),
      .DEN_W (32)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (rate_sel),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_released        = rsp_rel_ff;
   assign rsp_released_tag    = rsp_tag_ff;
   assign rsp_released_length = rsp_len_ff;
   assign rsp_dropped         = rsp_drop_ff;
   assign rsp_shaped          = rsp_shaped_ff;
   assign rsp_queue_count     = rsp_cnt_ff;

endmodule

@@ rtl/dtbs_checker.sv @@
module dtbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_released,
   input logic [15:0] rsp_released_tag,
   input logic [16:0] rsp_released_length,
   input logic        rsp_dropped,
   input logic        rsp_shaped
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result withdrawn");

   // one event kind per transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_released && (rsp_dropped || rsp_shaped))
                    && !(rsp_dropped && rsp_shaped))
      else $error("conflicting events in one result");

   // no release means empty release fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_released |-> rsp_released_tag == 16'd0
                                     && rsp_released_length == 17'd0)
      else $error("release fields set without release");

   // a stalled result keeps its released and shaped flags
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_released) && $stable(rsp_shaped))
      else $error("stalled result changed");

endmodule

bind dual_token_bucket_shaper dtbs_checker u_checker (.*);
